/* rtl/core/lottery_picker_with_aging_core_defines.svh */
// ----------------------------------------------------------------------------
// Lottery picker assertion macros
// Shared concurrent assertion forms for the lottery picker core.
// ----------------------------------------------------------------------------
`ifndef LOTTERY_PICKER_WITH_AGING_CORE_DEFINES_SVH
`define LOTTERY_PICKER_WITH_AGING_CORE_DEFINES_SVH

// same-cycle implication
`define LPA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lottery picker: same-cycle check failed");

// next-cycle implication
`define LPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lottery picker: next-cycle check failed");

`endif

/* rtl/core/lpa_pkg.sv */
// ----------------------------------------------------------------------------
// Lottery picker package
// Shared types, codes and default sizes for the lottery picker core.
// ----------------------------------------------------------------------------
package lpa_pkg;

   localparam int DEF_MAX_ENTRIES    = 16;
   localparam int DEF_TICKET_BITS    = 16;
   localparam int DEF_INCREMENT_BITS = 8;
   localparam int DEF_ALU_BITS       = 21;

   localparam int RANDOM_BITS = 32;
   localparam int MASK_BITS   = 16;
   localparam logic [19:0] TOTAL_OUT_MAX = 20'hFFFFF;

   typedef enum logic [1:0] {
      CMD_PICK   = 2'd0,
      CMD_UPDATE = 2'd1,
      CMD_INIT   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_ENTRY_COUNT       = 3'd0,
      REG_INITIAL_TICKETS   = 3'd1,
      REG_INITIAL_INCREMENT = 3'd2,
      REG_INCREMENT_CHANGE  = 3'd3,
      REG_MINIMUM_INCREMENT = 3'd4
   } reg_index_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] random_value;
      logic [15:0] update_mask;
      logic [3:0]  picked_index;
      logic        picked_valid;
   } req_type;

   typedef struct packed {
      logic [3:0]  chosen_index;
      logic        chosen_valid;
      logic [19:0] ticket_total;
   } rsp_type;

endpackage

/* rtl/core/lottery_picker_with_aging_core.sv */
// ----------------------------------------------------------------------------
// Lottery picker with aging - core
// Passes: pick runs a ticket sum, 32 modulo steps and a prefix scan;
// update is a read-modify-write sweep and init writes every entry;
// all passes share one adder and one table read port.
// A new transaction is taken in the strobe cycle; results cannot be stalled.
// Reset (synchronous) empties the table and loads register defaults.
// ----------------------------------------------------------------------------
`include "lottery_picker_with_aging_core_defines.svh"

module lottery_picker_with_aging_core #(
   parameter int MAX_ENTRIES    = lpa_pkg::DEF_MAX_ENTRIES,
   parameter int TICKET_BITS    = lpa_pkg::DEF_TICKET_BITS,
   parameter int INCREMENT_BITS = lpa_pkg::DEF_INCREMENT_BITS
) (
   input  logic             clock,
   input  logic             reset,
   // command channel
   input  logic             start,
   output logic             busy,
   input  lpa_pkg::req_type req_data,
   // result channel
   output logic             rsp_strobe,
   output lpa_pkg::rsp_type rsp_data,
   // register port
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   // ---------------------------------------------------------------------
   // Sizes
   // ---------------------------------------------------------------------
   localparam int AW  = $clog2(MAX_ENTRIES);           // entry address
   localparam int CW  = $clog2(MAX_ENTRIES + 1);       // entry count
   localparam int TB  = TICKET_BITS + AW;              // exact ticket total
   localparam int UW  = TB + 1;                        // shared adder width
   localparam int MW  = TICKET_BITS + INCREMENT_BITS;  // table word
   localparam int IW  = (AW > 5) ? AW : 5;             // index compare
   localparam int EW  = (CW > 5) ? CW : 5;             // entry_count compare
   localparam int TXW = (TICKET_BITS > 16) ? TICKET_BITS : 16;
   localparam int NXW = (INCREMENT_BITS > 8) ? INCREMENT_BITS : 8;
   localparam int XW  = ((INCREMENT_BITS > 9) ? INCREMENT_BITS : 9) + 2;
   localparam int OW  = (TB > 20) ? TB : 20;
   localparam int BCW = $clog2(lpa_pkg::RANDOM_BITS);

   // One-hot sequencer. SUM totals the active tickets for every command;
   // MOD is restoring division of random_value by the total, one bit per
   // cycle; SCAN subtracts tickets from the remainder until it borrows;
   // UPD is a read-modify-write sweep; INIT writes every entry.
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SUM  = 6'b000010,
      ST_MOD  = 6'b000100,
      ST_SCAN = 6'b001000,
      ST_UPD  = 6'b010000,
      ST_INIT = 6'b100000
   } state_type;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [4:0]        cfg_count_ff;
   logic [15:0]       cfg_init_tick_ff;
   logic [7:0]        cfg_init_inc_ff;
   logic signed [8:0] cfg_change_ff;
   logic [7:0]        cfg_min_inc_ff;
   logic              csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_count_ff     <= '0;
         cfg_init_tick_ff <= '0;
         cfg_init_inc_ff  <= 8'd1;
         cfg_change_ff    <= '0;
         cfg_min_inc_ff   <= 8'd1;
      end else if (csr_write) begin
         unique case (paddr[4:2])
            lpa_pkg::REG_ENTRY_COUNT:       cfg_count_ff     <= pwdata[4:0];
            lpa_pkg::REG_INITIAL_TICKETS:   cfg_init_tick_ff <= pwdata[15:0];
            lpa_pkg::REG_INITIAL_INCREMENT: cfg_init_inc_ff  <= pwdata[7:0];
            lpa_pkg::REG_INCREMENT_CHANGE:  cfg_change_ff    <= $signed(pwdata[8:0]);
            lpa_pkg::REG_MINIMUM_INCREMENT: cfg_min_inc_ff   <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         lpa_pkg::REG_ENTRY_COUNT:       prdata = 32'(cfg_count_ff);
         lpa_pkg::REG_INITIAL_TICKETS:   prdata = 32'(cfg_init_tick_ff);
         lpa_pkg::REG_INITIAL_INCREMENT: prdata = 32'(cfg_init_inc_ff);
         lpa_pkg::REG_INCREMENT_CHANGE:  prdata = 32'($unsigned(cfg_change_ff));
         lpa_pkg::REG_MINIMUM_INCREMENT: prdata = 32'(cfg_min_inc_ff);
         default:                        prdata = '0;
      endcase
   end

   // Register values clipped to the table's field widths
   logic [TXW-1:0]            init_tick_ext;
   logic [NXW-1:0]            init_inc_ext;
   logic [NXW-1:0]            min_inc_ext;
   logic [TICKET_BITS-1:0]    init_tick_sat;
   logic [INCREMENT_BITS-1:0] init_inc_sat;
   logic [INCREMENT_BITS-1:0] min_inc_sat;
   logic [CW-1:0]             active_count;

   always_comb begin
      init_tick_ext = TXW'(cfg_init_tick_ff);
      init_inc_ext  = NXW'(cfg_init_inc_ff);
      min_inc_ext   = NXW'(cfg_min_inc_ff);
      init_tick_sat = (init_tick_ext > TXW'({TICKET_BITS{1'b1}})) ?
                      '1 : init_tick_ext[TICKET_BITS-1:0];
      init_inc_sat  = (init_inc_ext > NXW'({INCREMENT_BITS{1'b1}})) ?
                      '1 : init_inc_ext[INCREMENT_BITS-1:0];
      min_inc_sat   = (min_inc_ext > NXW'({INCREMENT_BITS{1'b1}})) ?
                      '1 : min_inc_ext[INCREMENT_BITS-1:0];
      // entry_count above the table depth counts as the full table
      active_count  = (EW'(cfg_count_ff) > EW'(MAX_ENTRIES)) ?
                      CW'(MAX_ENTRIES) : CW'(cfg_count_ff);
   end

   // ---------------------------------------------------------------------
   // Entry table: {increment, tickets}, one write and one registered read
   // port. Valid bits make never-written entries read as zero after reset.
   // ---------------------------------------------------------------------
   logic [MW-1:0]          mem [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] vbits_ff;
   logic [MW-1:0]          rd_data_ff;
   logic                   rd_ok_ff;
   logic                   pend_ff;
   logic [AW-1:0]          pidx_ff;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [MW-1:0]          mem_wdata;
   logic                   issue;

   state_type              state_ff, state_in;
   logic [CW-1:0]          addr_ff, addr_in;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[addr_ff[AW-1:0]];
      rd_ok_ff   <= vbits_ff[addr_ff[AW-1:0]];
      pidx_ff    <= addr_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vbits_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         if (mem_we) begin
            vbits_ff[mem_waddr] <= 1'b1;
         end
         pend_ff <= issue;   // rd_data_ff holds entry pidx_ff next cycle
      end
   end

   logic [TICKET_BITS-1:0]    ent_tick;
   logic [INCREMENT_BITS-1:0] ent_inc;

   assign ent_tick = rd_ok_ff ? rd_data_ff[TICKET_BITS-1:0] : '0;
   assign ent_inc  = rd_ok_ff ? rd_data_ff[MW-1:TICKET_BITS] : '0;

   // ---------------------------------------------------------------------
   // Shared adder
   // ---------------------------------------------------------------------
   lpa_pkg::alu_op_type alu_op;
   logic [UW-1:0]       alu_a;
   logic [UW-1:0]       alu_b;
   logic [UW:0]         alu_res;
   logic                borrow;

   lpa_alu #(
      .WIDTH (UW)
   ) u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res)
   );

   assign borrow = alu_res[UW];

   // ---------------------------------------------------------------------
   // Picked-entry increment: add the signed change, floor, saturate
   // ---------------------------------------------------------------------
   logic signed [XW-1:0]      inc_next;
   logic signed [XW-1:0]      floor_s;
   logic signed [XW-1:0]      inc_max_s;
   logic [INCREMENT_BITS-1:0] inc_clamped;

   always_comb begin
      inc_next    = $signed(XW'(ent_inc)) + XW'(cfg_change_ff);
      floor_s     = $signed(XW'(min_inc_sat));
      inc_max_s   = $signed(XW'({INCREMENT_BITS{1'b1}}));
      if (inc_next < floor_s) begin
         inc_clamped = min_inc_sat;
      end else if (inc_next > inc_max_s) begin
         inc_clamped = '1;
      end else begin
         inc_clamped = inc_next[INCREMENT_BITS-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   lpa_pkg::req_type      req_ff, req_in;
   logic [CW-1:0]         n_ff, n_in;
   logic [TB-1:0]         total_ff, total_in;
   logic [TB-1:0]         rem_ff, rem_in;
   logic [BCW-1:0]        bit_cnt_ff, bit_cnt_in;
   logic [AW-1:0]         chosen_ff, chosen_in;
   logic                  found_ff, found_in;
   lpa_pkg::rsp_type      rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  finish;
   logic [IW-1:0]         pidx_w;
   logic                  mask_hit;
   logic                  pick_hit;
   logic [TICKET_BITS-1:0] tick_sum_sat;
   logic [OW-1:0]         total_ext;

   always_comb begin
      pidx_w       = IW'(pidx_ff);
      // mask covers only the first MASK_BITS entries
      mask_hit     = (pidx_w < IW'(lpa_pkg::MASK_BITS)) &&
                     req_ff.update_mask[pidx_w[3:0]];
      pick_hit     = req_ff.picked_valid && (IW'(req_ff.picked_index) == pidx_w);
      tick_sum_sat = (|alu_res[UW:TICKET_BITS]) ? '1 : alu_res[TICKET_BITS-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      req_in       = req_ff;
      n_in         = n_ff;
      total_in     = total_ff;
      rem_in       = rem_ff;
      bit_cnt_in   = bit_cnt_ff;
      chosen_in    = chosen_ff;
      found_in     = found_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      finish       = 1'b0;
      issue        = 1'b0;
      alu_op       = lpa_pkg::ALU_ADD;
      alu_a        = '0;
      alu_b        = '0;
      mem_we       = 1'b0;
      mem_waddr    = pidx_ff;
      mem_wdata    = '0;
      total_ext    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in     = req_data;
               n_in       = active_count;
               addr_in    = '0;
               total_in   = '0;
               rem_in     = '0;
               bit_cnt_in = '0;
               chosen_in  = '0;
               found_in   = 1'b0;
               state_in   = ST_SUM;
            end
         end

         ST_SUM: begin
            issue = (addr_ff < n_ff);
            if (issue) begin
               addr_in = CW'(addr_ff + 1'b1);
            end
            alu_a = UW'(total_ff);
            alu_b = UW'(ent_tick);
            if (pend_ff) begin
               total_in = alu_res[TB-1:0];
            end
            if (!issue) begin
               addr_in = '0;
               case (req_ff.command)
                  lpa_pkg::CMD_PICK: begin
                     if (total_in == '0) begin
                        finish = 1'b1;
                     end else begin
                        state_in = ST_MOD;
                     end
                  end
                  lpa_pkg::CMD_UPDATE: state_in = ST_UPD;
                  lpa_pkg::CMD_INIT:   state_in = ST_INIT;
                  default:             finish   = 1'b1;
               endcase
            end
         end

         ST_MOD: begin
            // restoring step: shift in the next dividend bit, trial subtract
            alu_op = lpa_pkg::ALU_SUB;
            alu_a  = {rem_ff, req_ff.random_value[lpa_pkg::RANDOM_BITS-1]};
            alu_b  = UW'(total_ff);
            rem_in = borrow ? alu_a[TB-1:0] : alu_res[TB-1:0];
            req_in.random_value = {req_ff.random_value[lpa_pkg::RANDOM_BITS-2:0], 1'b0};
            bit_cnt_in = BCW'(bit_cnt_ff + 1'b1);
            if (bit_cnt_ff == BCW'(lpa_pkg::RANDOM_BITS - 1)) begin
               addr_in  = '0;
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // first entry whose ticket count exceeds what is left wins
            issue = (addr_ff < n_ff);
            if (issue) begin
               addr_in = CW'(addr_ff + 1'b1);
            end
            alu_op = lpa_pkg::ALU_SUB;
            alu_a  = UW'(rem_ff);
            alu_b  = UW'(ent_tick);
            if (pend_ff && borrow) begin
               found_in  = 1'b1;
               chosen_in = pidx_ff;
               finish    = 1'b1;
            end else if (pend_ff) begin
               rem_in = alu_res[TB-1:0];
            end
            if (!issue) begin
               finish = 1'b1;
            end
         end

         ST_UPD: begin
            issue = (addr_ff < n_ff);
            if (issue) begin
               addr_in = CW'(addr_ff + 1'b1);
            end
            alu_a = UW'(ent_tick);
            alu_b = UW'(ent_inc);
            if (pend_ff) begin
               // picked entry: new increment, tickets cleared (wins over mask)
               if (pick_hit) begin
                  mem_we    = 1'b1;
                  mem_wdata = {inc_clamped, {TICKET_BITS{1'b0}}};
               end else if (mask_hit) begin
                  mem_we    = 1'b1;
                  mem_wdata = {ent_inc, tick_sum_sat};
               end
            end
            if (!issue) begin
               finish = 1'b1;
            end
         end

         ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = addr_ff[AW-1:0];
            mem_wdata = {init_inc_sat, init_tick_sat};
            addr_in   = CW'(addr_ff + 1'b1);
            if (addr_ff == CW'(MAX_ENTRIES - 1)) begin
               finish = 1'b1;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      if (finish) begin
         state_in            = ST_IDLE;
         rsp_valid_in        = 1'b1;
         rsp_in.chosen_valid = found_in;
         rsp_in.chosen_index = found_in ? 4'(chosen_in) : 4'd0;
         total_ext           = OW'(total_in);
         rsp_in.ticket_total = (total_ext > OW'(lpa_pkg::TOTAL_OUT_MAX)) ?
                               lpa_pkg::TOTAL_OUT_MAX : total_ext[19:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      req_ff     <= req_in;
      n_ff       <= n_in;
      total_ff   <= total_in;
      rem_ff     <= rem_in;
      bit_cnt_ff <= bit_cnt_in;
      chosen_ff  <= chosen_in;
      found_ff   <= found_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   `LPA_ASSERT_NEXT(a_accept_goes_busy, clock, reset, start && !busy, busy)
   `LPA_ASSERT_NOW(a_result_when_idle, clock, reset, rsp_strobe, !busy)
   `LPA_ASSERT_NOW(a_result_after_work, clock, reset, rsp_strobe, $past(busy))
   `LPA_ASSERT_NOW(a_valid_pick_has_total, clock, reset,
      rsp_strobe && rsp_data.chosen_valid, rsp_data.ticket_total != 20'd0)

endmodule

/* rtl/core/lpa_alu.sv */
// ----------------------------------------------------------------------------
// Lottery picker shared adder
// Add or subtract with carry/borrow out; the adder shared by all core passes.
// ----------------------------------------------------------------------------
module lpa_alu #(
   parameter int WIDTH = lpa_pkg::DEF_ALU_BITS
) (
   input  lpa_pkg::alu_op_type op,
   input  logic [WIDTH-1:0]    a,
   input  logic [WIDTH-1:0]    b,
   output logic [WIDTH:0]      res
);

   // res[WIDTH] is the carry on add, the borrow (a < b) on subtract
   always_comb begin
      if (op == lpa_pkg::ALU_SUB) begin
         res = {1'b0, a} - {1'b0, b};
      end else begin
         res = {1'b0, a} + {1'b0, b};
      end
   end

endmodule
